// File: rtl/spm_pkg.sv
// Shared types and constants for the sparse polynomial multiplier.
// Used by every module of the block; depends on nothing else.
package spm_pkg;

  localparam int MAX_EXP_DEF       = 31;
  localparam int PRODUCT_SLOTS_DEF = 63;
  localparam int COEF_W            = 32;
  localparam int TERM_EXP_W        = 5;
  localparam int PROD_EXP_W        = 6;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_MULT   = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [COEF_W-1:0] term_coef;
    logic [TERM_EXP_W-1:0]   term_exp;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] product_coef;
    logic [PROD_EXP_W-1:0]   product_exp;
    logic                    last_term;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_MULT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [COEF_W-1:0]     coef;
    logic [TERM_EXP_W-1:0] expo;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FLUSH
  } back_state_t;

endpackage

// File: rtl/spm_front.sv
// Front end: accepts input requests, classifies them and forwards useful ones.
// Depends on spm_pkg; feeds the command queue.
module spm_front import spm_pkg::*; #(
  parameter int MAX_EXP = MAX_EXP_DEF
) (
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     q_push,
  input  logic     q_full,
  output cmd_t     q_cmd
);

  localparam logic [TERM_EXP_W-1:0] EXP_LIMIT = TERM_EXP_W'(MAX_EXP);

  logic      keep;
  cmd_kind_t kind;

  // Terms beyond the store and the unused operation code are taken and dropped.
  always_comb begin
    keep = 1'b0;
    kind = CMD_MULT;
    case (item.operation)
      OP_LOAD_A: begin
        kind = CMD_LOAD_A;
        keep = (item.term_exp <= EXP_LIMIT);
      end
      OP_LOAD_B: begin
        kind = CMD_LOAD_B;
        keep = (item.term_exp <= EXP_LIMIT);
      end
      OP_MULT: begin
        kind = CMD_MULT;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full       = q_full;
  assign q_push     = push && !q_full && keep;
  assign q_cmd.kind = kind;
  assign q_cmd.coef = item.term_coef;
  assign q_cmd.expo = item.term_exp;

endmodule

// File: rtl/spm_queue.sv
// Short command queue between the front end and the back end.
// Depends on spm_pkg for the command type and its depth.
module spm_queue import spm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t dout
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/spm_back.sv
// Back end: coefficient stores, the multiply-accumulate pipeline and the
// result register. Depends on spm_pkg; takes commands from spm_queue.
module spm_back import spm_pkg::*; #(
  parameter int MAX_EXP       = MAX_EXP_DEF,
  parameter int PRODUCT_SLOTS = PRODUCT_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  localparam int DEPTH = MAX_EXP + 1;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = PROD_EXP_W;
  localparam int S_TOP = (PRODUCT_SLOTS - 1 < 2 * MAX_EXP) ? PRODUCT_SLOTS - 1 : 2 * MAX_EXP;
  localparam logic [SW-1:0] S_MAX = SW'(MAX_EXP);

  back_state_t state;
  back_state_t state_next;

  // Coefficient stores; an entry that is not valid reads as zero.
  logic [COEF_W-1:0] a_store [DEPTH];
  logic [COEF_W-1:0] b_store [DEPTH];
  logic [DEPTH-1:0]  a_vld;
  logic [DEPTH-1:0]  b_vld;

  // Pair sequencer: product slot s from the top down, index i of A within it.
  logic [SW-1:0] s_cnt;
  logic [IW-1:0] i_cnt;
  logic [IW-1:0] i_lo;
  logic [IW-1:0] i_hi;
  logic [IW-1:0] i_lo_dec;
  logic [SW-1:0] s_dec;
  logic [IW-1:0] j_idx;
  logic          slot_end;
  logic          issue;

  // Operand stage.
  logic              op_vld;
  logic [COEF_W-1:0] a_op;
  logic [COEF_W-1:0] b_op;
  logic              op_first;
  logic              op_slot_end;
  logic              op_final;
  logic [SW-1:0]     op_s;

  // Product stage.
  logic              pr_vld;
  logic [COEF_W-1:0] prod;
  logic              pr_first;
  logic              pr_slot_end;
  logic              pr_final;
  logic [SW-1:0]     pr_s;

  // Accumulator and the one product term held back until its successor is known.
  logic [COEF_W-1:0] acc_sum;
  logic [COEF_W-1:0] acc_val;
  logic              pend_vld;
  logic [COEF_W-1:0] pend_coef;
  logic [SW-1:0]     pend_exp;

  logic      res_vld;
  logic      adv;
  logic      slot_done;
  logic      slot_nz;
  logic      emit;
  logic      flush;
  logic      load;
  out_item_t emit_item;
  logic [IW-1:0] ld_idx;

  assign adv   = !res_vld || pop;
  assign empty = !res_vld;

  assign s_dec    = s_cnt - 1'b1;
  assign i_lo     = (s_cnt > S_MAX) ? IW'(s_cnt - S_MAX) : '0;
  assign i_hi     = (s_cnt < S_MAX) ? IW'(s_cnt) : IW'(MAX_EXP);
  assign i_lo_dec = (s_dec > S_MAX) ? IW'(s_dec - S_MAX) : '0;
  assign j_idx    = IW'(s_cnt - SW'(i_cnt));
  assign slot_end = (i_cnt == i_hi);
  assign ld_idx   = q_cmd.expo[IW-1:0];

  assign acc_val   = pr_first ? prod : acc_sum + prod;
  assign slot_done = adv && pr_vld && pr_slot_end;
  assign slot_nz   = (acc_val != '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty && q_cmd.kind == CMD_MULT) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (adv && slot_end && s_cnt == '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (slot_done && pr_final) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    issue = 1'b0;
    flush = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop = !q_empty;
        load  = !q_empty && (q_cmd.kind inside {CMD_LOAD_A, CMD_LOAD_B});
      end
      ST_MAC: begin
        issue = adv;
      end
      ST_FLUSH: begin
        flush = adv;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign emit = slot_done && slot_nz && pend_vld;

  always_comb begin
    emit_item.product_coef = pend_coef;
    emit_item.product_exp  = pend_exp;
    emit_item.last_term    = 1'b0;
    if (flush) begin
      emit_item.last_term = 1'b1;
      if (!pend_vld) begin
        // An all-zero product still reports one term.
        emit_item.product_coef = '0;
        emit_item.product_exp  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_cmd.kind == CMD_LOAD_A) begin
      a_store[ld_idx] <= (a_vld[ld_idx] ? a_store[ld_idx] : '0) + q_cmd.coef;
    end
    if (load && q_cmd.kind == CMD_LOAD_B) begin
      b_store[ld_idx] <= (b_vld[ld_idx] ? b_store[ld_idx] : '0) + q_cmd.coef;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      a_vld <= '0;
      b_vld <= '0;
    end else if (load) begin
      if (q_cmd.kind == CMD_LOAD_A) begin
        a_vld[ld_idx] <= 1'b1;
      end else begin
        b_vld[ld_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      s_cnt <= SW'(S_TOP);
      i_cnt <= (SW'(S_TOP) > S_MAX) ? IW'(SW'(S_TOP) - S_MAX) : '0;
    end else if (issue) begin
      if (slot_end) begin
        s_cnt <= s_dec;
        i_cnt <= i_lo_dec;
      end else begin
        i_cnt <= i_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op        <= a_vld[i_cnt] ? a_store[i_cnt] : '0;
      b_op        <= b_vld[j_idx] ? b_store[j_idx] : '0;
      op_first    <= (i_cnt == i_lo);
      op_slot_end <= slot_end;
      op_final    <= slot_end && (s_cnt == '0);
      op_s        <= s_cnt;
      prod        <= COEF_W'(a_op * b_op);
      pr_first    <= op_first;
      pr_slot_end <= op_slot_end;
      pr_final    <= op_final;
      pr_s        <= op_s;
    end
    if (adv && pr_vld) begin
      acc_sum <= acc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld <= 1'b0;
      pr_vld <= 1'b0;
    end else if (adv) begin
      op_vld <= issue;
      pr_vld <= op_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      pend_vld <= 1'b0;
    end else if (slot_done && slot_nz) begin
      pend_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_done && slot_nz) begin
      pend_coef <= acc_val;
      pend_exp  <= pr_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (emit || flush) begin
      res_vld <= 1'b1;
    end else if (pop) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit || flush) begin
      result <= emit_item;
    end
  end

endmodule

// File: rtl/sparse_polynomial_multiplier_unit.sv
// Sparse polynomial multiplier, top level.
// Input requests carry an operation: add a term to A, add a term to B, or
// multiply. Both sides are queues: a request enters when push is high and
// full is low; a product term leaves when pop is high and empty is low.
// A term load is merged into its coefficient store at the edge it leaves the
// four-entry command queue, so loads stream at one per cycle while no
// multiply is in progress.
// A multiply walks every pair of A and B exponents whose sum fits the
// product, one pair per cycle unless a waiting result holds the pipeline,
// via a three-stage multiply-accumulate pipeline with a single multiplier,
// product slots from the highest down. Nonzero terms come out highest
// exponent first, the final one with last_term set; an all-zero product
// gives one zero term. The stores are then cleared.
// While a result waits unpopped the pipeline holds; the queue keeps taking
// requests until it fills. Reset empties the queue, the stores and the
// result register.
// Depends on spm_pkg, spm_front, spm_queue and spm_back.
module sparse_polynomial_multiplier_unit import spm_pkg::*; #(
  parameter int MAX_EXP       = MAX_EXP_DEF,
  parameter int PRODUCT_SLOTS = PRODUCT_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_din;
  cmd_t q_dout;

  spm_front #(
    .MAX_EXP(MAX_EXP)
  ) u_front (
    .push  (push),
    .full  (full),
    .item  (item),
    .q_push(q_push),
    .q_full(q_full),
    .q_cmd (q_din)
  );

  spm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .dout (q_dout)
  );

  spm_back #(
    .MAX_EXP      (MAX_EXP),
    .PRODUCT_SLOTS(PRODUCT_SLOTS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_cmd  (q_dout),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// File: tb/sv/tb_sparse_polynomial_multiplier_unit.sv
`timescale 1ns / 1ps
// Testbench for sparse_polynomial_multiplier_unit: a directed table, then random term batches.
// Typed rows check the table's term, all other terms a behavioral multiplier kept in this file.
// Depends on spm_pkg and the RTL of the block.
module tb_sparse_polynomial_multiplier_unit;
  import spm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_GOAL     = 380;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 1200;
  localparam int PRINT_CAP     = 60;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t term;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  item = '0;
  out_item_t result;

  bit [COEF_W-1:0] coef_a [MAX_EXP_DEF+1];
  bit [COEF_W-1:0] coef_b [MAX_EXP_DEF+1];
  out_item_t       new_terms[$];
  out_item_t       pending_terms[$];
  directed_row_t   directed_rows[$];
  int              mismatches = 0;
  int              cycles = 0;
  bit              steady = 1'b0;

  sparse_polynomial_multiplier_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sparse_polynomial_multiplier_unit verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Behavioral multiplier: merges loads into dense stores and, on a multiply request,
  // fills new_terms with the nonzero product terms, highest exponent first.
  task automatic multiply_terms(input in_item_t r);
    bit [COEF_W-1:0] sums [PRODUCT_SLOTS_DEF];
    out_item_t t;
    new_terms.delete();
    case (r.operation)
      OP_LOAD_A: if (r.term_exp <= MAX_EXP_DEF) coef_a[r.term_exp] += r.term_coef;
      OP_LOAD_B: if (r.term_exp <= MAX_EXP_DEF) coef_b[r.term_exp] += r.term_coef;
      OP_MULT: begin
        for (int s = 0; s < PRODUCT_SLOTS_DEF; s++) sums[s] = '0;
        for (int i = 0; i <= MAX_EXP_DEF; i++) begin
          for (int j = 0; j <= MAX_EXP_DEF; j++) begin
            if (i + j < PRODUCT_SLOTS_DEF) sums[i+j] += coef_a[i] * coef_b[j];
          end
        end
        for (int s = PRODUCT_SLOTS_DEF - 1; s >= 0; s--) begin
          if (sums[s] != '0) begin
            t.product_coef = sums[s];
            t.product_exp  = PROD_EXP_W'(s);
            t.last_term    = 1'b0;
            new_terms.push_back(t);
          end
        end
        // An all-zero product still answers with a single zero term.
        if (new_terms.size() == 0) begin
          t = '0;
          t.last_term = 1'b1;
          new_terms.push_back(t);
        end else begin
          new_terms[new_terms.size()-1].last_term = 1'b1;
        end
        for (int i = 0; i <= MAX_EXP_DEF; i++) begin
          coef_a[i] = '0;
          coef_b[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input in_item_t r, input bit typed, input out_item_t typed_term);
    if (!steady && $urandom_range(0, 99) < 10) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    item <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    multiply_terms(r);
    if (typed) begin
      pending_terms.push_back(typed_term);
    end else begin
      foreach (new_terms[k]) pending_terms.push_back(new_terms[k]);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending_terms.size() != 0);
  endtask

  function automatic directed_row_t table_row(input logic [1:0] op, input logic [31:0] coef,
                                              input logic [4:0] e, input bit typed,
                                              input logic [31:0] want_coef,
                                              input logic [5:0] want_exp);
    directed_row_t row;
    row.req.operation     = op;
    row.req.term_coef     = coef;
    row.req.term_exp      = e;
    row.typed             = typed;
    row.term.product_coef = want_coef;
    row.term.product_exp  = want_exp;
    row.term.last_term    = 1'b1;
    return row;
  endfunction

  always @(posedge clk) begin
    pop <= steady || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin : check_terms
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_terms.size() == 0) begin
        report_mismatch($sformatf("unexpected term coef %0d exp %0d last %0b",
                                  result.product_coef, result.product_exp,
                                  result.last_term));
      end else begin
        want = pending_terms.pop_front();
        if (result.product_coef !== want.product_coef)
          report_mismatch($sformatf("product_coef %0d, expected %0d (exp %0d)",
                                    result.product_coef, want.product_coef,
                                    want.product_exp));
        if (result.product_exp !== want.product_exp)
          report_mismatch($sformatf("product_exp %0d, expected %0d",
                                    result.product_exp, want.product_exp));
        if (result.last_term !== want.last_term)
          report_mismatch($sformatf("last_term %0b, expected %0b (exp %0d)",
                                    result.last_term, want.last_term, want.product_exp));
      end
    end
  end

  initial begin
    in_item_t r;
    int sent;
    int batch;
    int style;
    int n;
    int side;
    int pick;

    sent  = 0;
    batch = 0;
    for (int i = 0; i <= MAX_EXP_DEF; i++) begin
      coef_a[i] = '0;
      coef_b[i] = '0;
    end

    // Multiply on empty stores right after reset gives the single zero term.
    directed_rows.push_back(table_row(OP_MULT, 32'h0, 5'd0, 1'b1, 32'h0, 6'd0));
    directed_rows.push_back(table_row(OP_LOAD_A, 32'h1, 5'd0, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_B, 32'h1, 5'd0, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_MULT, 32'h0, 5'd0, 1'b1, 32'h1, 6'd0));
    // Highest exponents and largest magnitudes; the product wraps.
    directed_rows.push_back(table_row(OP_LOAD_A, 32'h7FFFFFFF, 5'd31, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_B, 32'hFFFFFFFF, 5'd31, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_MULT, 32'hFFFFFFFF, 5'd31, 1'b1, 32'h80000001, 6'd62));
    directed_rows.push_back(table_row(OP_LOAD_A, 32'h80000000, 5'd31, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_B, 32'h80000000, 5'd31, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_MULT, 32'h0, 5'd0, 1'b1, 32'h0, 6'd0));
    // Two loads to one exponent merge and wrap in the store.
    directed_rows.push_back(table_row(OP_LOAD_A, 32'h7FFFFFFF, 5'd5, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_A, 32'h1, 5'd5, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_B, 32'h1, 5'd0, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_MULT, 32'h0, 5'd0, 1'b1, 32'h80000000, 6'd5));
    // The unused operation code must leave the stores alone.
    directed_rows.push_back(table_row(OP_LOAD_A, 32'h2, 5'd0, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_B, 32'h3, 5'd0, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_UNUSED, 32'hFFFFFFFF, 5'd31, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_MULT, 32'h0, 5'd0, 1'b1, 32'h6, 6'd0));
    directed_rows.push_back(table_row(OP_LOAD_A, 32'hAAAAAAAA, 5'd21, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_A, 32'h1, 5'd10, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_B, 32'h1, 5'd31, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_LOAD_B, 32'hFFFFFFFF, 5'd0, 1'b0, '0, '0));
    directed_rows.push_back(table_row(OP_MULT, 32'h55555555, 5'd10, 1'b0, '0, '0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].term);
      if (directed_rows[k].req.operation != OP_UNUSED) sent++;
    end
    wait_drained();

    // Random batches: a run of loads with random content, then a multiply.
    while (sent < ITEM_GOAL) begin
      batch++;
      steady = (batch >= 15 && batch < 27);
      if (batch % 12 == 0) wait_drained();
      style = $urandom_range(0, 99);
      if (style < 8) begin
        // Dense operands: every product slot comes out nonzero.
        for (int e = 0; e <= MAX_EXP_DEF; e++) begin
          r.operation = OP_LOAD_A;
          r.term_coef = $urandom_range(1, 7);
          r.term_exp  = TERM_EXP_W'(e);
          send_request(r, 1'b0, '0);
          r.operation = OP_LOAD_B;
          r.term_coef = 0 - $urandom_range(1, 7);
          send_request(r, 1'b0, '0);
          sent += 2;
        end
      end else begin
        n    = $urandom_range(0, 10);
        side = $urandom_range(0, 9);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 99) < 4) begin
            r.operation = OP_UNUSED;
            r.term_coef = $urandom;
            r.term_exp  = TERM_EXP_W'($urandom_range(0, 31));
            send_request(r, 1'b0, '0);
          end
          if (side == 0) r.operation = OP_LOAD_A;
          else if (side == 1) r.operation = OP_LOAD_B;
          else r.operation = $urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B;
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            r.term_coef = $urandom_range(0, 8) - 4;
          end else if (pick < 8) begin
            r.term_coef = $urandom;
          end else begin
            case ($urandom_range(0, 3))
              0: r.term_coef = 32'h7FFFFFFF;
              1: r.term_coef = 32'h80000000;
              2: r.term_coef = 32'hFFFFFFFF;
              default: r.term_coef = 32'h1;
            endcase
          end
          // Half the terms crowd onto low exponents so that they merge.
          r.term_exp = TERM_EXP_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, 3));
          send_request(r, 1'b0, '0);
          sent++;
        end
      end
      r.operation = OP_MULT;
      r.term_coef = $urandom;
      r.term_exp  = TERM_EXP_W'($urandom_range(0, 31));
      send_request(r, 1'b0, '0);
      sent++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sparse_polynomial_multiplier_unit verification clean");
    end else begin
      $display("sparse_polynomial_multiplier_unit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/spm_pkg.sv
rtl/spm_front.sv
rtl/spm_queue.sv
rtl/spm_back.sv
rtl/sparse_polynomial_multiplier_unit.sv
tb/sv/tb_sparse_polynomial_multiplier_unit.sv
